// ----- hw/rtl/lsos_pkg.sv -----
// ----------------------------------------------------------------------------
// lsos_pkg: shared types and constants of the log structured object store
// Sizes, entry layout, opcodes, status codes and controller/datapath links.
// ----------------------------------------------------------------------------
package lsos_pkg;

    localparam int ENTRY_SLOTS    = 32;
    localparam int DATA_HALFWORDS = 1024;

    localparam int SLOT_W = $clog2(ENTRY_SLOTS);
    localparam int CNT_W  = $clog2(ENTRY_SLOTS + 1);
    localparam int ADDR_W = $clog2(DATA_HALFWORDS);
    localparam int FILL_W = $clog2(DATA_HALFWORDS + 1);
    localparam int HW_W   = 15;

    localparam logic [15:0] INVALID_ID = 16'hFFFF;
    localparam logic [16:0] NO_ID      = 17'h10000;

    typedef enum logic [1:0] {
        MODE_HDR  = 2'd0,
        MODE_DATA = 2'd1,
        MODE_READ = 2'd2,
        MODE_RSVD = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        RS_OK   = 2'd0,
        RS_BAD  = 2'd1,
        RS_FULL = 2'd2,
        RS_SEQ  = 2'd3
    } t_status;

    typedef struct packed {
        logic [15:0]       id;
        logic [15:0]       len;
        logic [FILL_W-1:0] addr;
    } t_entry;

    typedef enum logic [4:0] {
        OP_NOP, OP_LATCH, OP_RES, OP_DATA_WR,
        OP_R_INIT, OP_R_ADDR, OP_R_HIT, OP_D_ADDR, OP_D_CAP,
        OP_C_INIT, OP_C_SCAN0, OP_C_ADDR, OP_C_CHK, OP_C_PICK, OP_C_ENT,
        OP_C_CPRD, OP_C_CPWR, OP_C_WENT, OP_C_END,
        OP_H_APP, OP_H_CLR, OP_H_FIN, OP_EMIT
    } t_op;

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE,
        S_R_INIT, S_R_ADDR, S_R_CHK, S_R_DATA, S_R_DCAP,
        S_C_INIT, S_C_SCAN0, S_C_ADDR, S_C_CHK, S_C_PICK, S_C_ENT,
        S_C_CPRD, S_C_CPWR, S_C_WENT, S_H_CHK2,
        S_H_APP, S_H_CLR, S_H_FIN, S_DONE
    } t_state;

    typedef struct packed {
        t_op     op;
        t_status code;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  hdr_bad;
        logic  rd_bad;
        logic  pend_nz;
        logic  over;
        logic  k_zero;
        logic  id_match;
        logic  len_zero;
        logic  rd_ok;
        logic  scan_end;
        logic  none_found;
        logic  cnt_full;
        logic  step_done;
        logic  out_free;
    } t_dp_stat;

endpackage

// ----- hw/rtl/lsos_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsos_ctrl: sequencer of the object store
// Walks each request through header, data, read and compaction steps.
// ----------------------------------------------------------------------------
module lsos_ctrl import lsos_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_cmd     o_cmd,
    output logic     o_busy
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.op   = OP_NOP;
        o_cmd.code = RS_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LATCH;
                    n_state  = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state  = S_DONE;
                o_cmd.op = OP_RES;
                unique case (i_stat.mode)
                    MODE_HDR: begin
                        priority if (i_stat.hdr_bad) begin
                            o_cmd.code = RS_BAD;
                        end else if (i_stat.pend_nz) begin
                            o_cmd.code = RS_SEQ;
                        end else if (i_stat.over) begin
                            o_cmd.op = OP_NOP;
                            n_state  = S_C_INIT;
                        end else begin
                            o_cmd.op = OP_NOP;
                            n_state  = S_H_APP;
                        end
                    end
                    MODE_DATA: begin
                        if (i_stat.pend_nz) begin
                            o_cmd.op = OP_DATA_WR;
                        end else begin
                            o_cmd.code = RS_SEQ;
                        end
                    end
                    MODE_READ: begin
                        if (i_stat.rd_bad) begin
                            o_cmd.code = RS_BAD;
                        end else begin
                            o_cmd.op = OP_NOP;
                            n_state  = S_R_INIT;
                        end
                    end
                    default: begin
                        o_cmd.code = RS_BAD;
                    end
                endcase
            end
            S_R_INIT: begin
                o_cmd.op = OP_R_INIT;
                n_state  = S_R_ADDR;
            end
            S_R_ADDR: begin
                if (i_stat.k_zero) begin
                    o_cmd.op = OP_RES;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_R_ADDR;
                    n_state  = S_R_CHK;
                end
            end
            S_R_CHK: begin
                priority if (!i_stat.id_match) begin
                    n_state = S_R_ADDR;
                end else if (i_stat.len_zero) begin
                    o_cmd.op = OP_RES;
                    n_state  = S_DONE;
                end else begin
                    o_cmd.op = OP_R_HIT;
                    n_state  = i_stat.rd_ok ? S_R_DATA : S_DONE;
                end
            end
            S_R_DATA: begin
                o_cmd.op = OP_D_ADDR;
                n_state  = S_R_DCAP;
            end
            S_R_DCAP: begin
                o_cmd.op = OP_D_CAP;
                n_state  = S_DONE;
            end
            S_C_INIT: begin
                o_cmd.op = OP_C_INIT;
                n_state  = S_C_SCAN0;
            end
            S_C_SCAN0: begin
                o_cmd.op = OP_C_SCAN0;
                n_state  = S_C_ADDR;
            end
            S_C_ADDR: begin
                if (i_stat.scan_end) begin
                    n_state = S_C_PICK;
                end else begin
                    o_cmd.op = OP_C_ADDR;
                    n_state  = S_C_CHK;
                end
            end
            S_C_CHK: begin
                o_cmd.op = OP_C_CHK;
                n_state  = S_C_ADDR;
            end
            S_C_PICK: begin
                if (i_stat.none_found || i_stat.cnt_full) begin
                    o_cmd.op = OP_C_END;
                    n_state  = S_H_CHK2;
                end else begin
                    o_cmd.op = OP_C_PICK;
                    n_state  = S_C_ENT;
                end
            end
            S_C_ENT: begin
                o_cmd.op = OP_C_ENT;
                n_state  = S_C_CPRD;
            end
            S_C_CPRD: begin
                if (i_stat.step_done) begin
                    n_state = S_C_WENT;
                end else begin
                    o_cmd.op = OP_C_CPRD;
                    n_state  = S_C_CPWR;
                end
            end
            S_C_CPWR: begin
                o_cmd.op = OP_C_CPWR;
                n_state  = S_C_CPRD;
            end
            S_C_WENT: begin
                o_cmd.op = OP_C_WENT;
                n_state  = S_C_SCAN0;
            end
            S_H_CHK2: begin
                if (i_stat.over) begin
                    o_cmd.op   = OP_RES;
                    o_cmd.code = RS_FULL;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_H_APP;
                end
            end
            S_H_APP: begin
                o_cmd.op = OP_H_APP;
                n_state  = S_H_CLR;
            end
            S_H_CLR: begin
                if (i_stat.step_done) begin
                    n_state = S_H_FIN;
                end else begin
                    o_cmd.op = OP_H_CLR;
                end
            end
            S_H_FIN: begin
                o_cmd.op = OP_H_FIN;
                n_state  = S_DONE;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_EMIT;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/lsos_dpath.sv -----
// ----------------------------------------------------------------------------
// lsos_dpath: datapath of the object store
// Entry and data memories, bank counters, scan registers and result buffer.
// ----------------------------------------------------------------------------
module lsos_dpath import lsos_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_object_id,
    input  logic [15:0] i_length_bytes,
    input  logic [15:0] i_read_offset,
    input  logic [15:0] i_max_length,
    input  logic [15:0] i_data_in,
    input  logic        i_out_stall,
    output t_dp_stat    o_stat,
    output logic        o_out_valid,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [15:0] o_read_length,
    output logic [15:0] o_data_out
);

    // latched request
    logic [1:0]  r_mode;
    logic [15:0] r_id, r_len, r_off, r_maxl, r_din;

    // store bookkeeping
    logic              r_active;
    logic [CNT_W-1:0]  r_cnt [2];
    logic [FILL_W-1:0] r_fill [2];
    logic [HW_W-1:0]   r_pend;

    // scan and copy state
    logic [CNT_W-1:0]  r_k;
    logic [SLOT_W-1:0] r_kidx, r_best;
    logic [16:0]       r_bestid;
    logic [15:0]       r_last;
    logic              r_first;
    logic [HW_W-1:0]   r_hw, r_i;
    logic [FILL_W-1:0] r_from, r_to;
    logic [15:0]       r_clen;

    // result
    t_status     r_rstat;
    logic        r_rfound;
    logic [15:0] r_rlen, r_rdout;
    logic        r_ovalid;

    // memories
    t_entry      mem_e [2][ENTRY_SLOTS];
    logic [15:0] mem_d [2][DATA_HALFWORDS];
    t_entry      r_erd;
    logic [15:0] r_drd;

    logic              w_dst;
    logic [CNT_W-1:0]  w_cnt_a, w_km1;
    logic [FILL_W-1:0] w_fill_a;
    logic [HW_W-1:0]   w_hw;
    logic [16:0]       w_rsum, w_ra;
    logic [15:0]       w_rlen;
    logic              w_elig;
    logic              w_out_take;

    logic              e_we, e_re, e_wb, e_rb;
    logic [SLOT_W-1:0] e_ws, e_rs;
    t_entry            e_wd;
    logic              d_we, d_re, d_wb, d_rb;
    logic [ADDR_W-1:0] d_wa, d_ra;
    logic [15:0]       d_wd;

    assign w_dst    = ~r_active;
    assign w_cnt_a  = r_cnt[r_active];
    assign w_fill_a = r_fill[r_active];
    assign w_km1    = r_k - CNT_W'(1);
    assign w_hw     = r_len[15:1];
    assign w_rsum   = {1'b0, r_maxl} + {1'b0, r_off};
    assign w_ra     = 17'(r_erd.addr) + 17'(r_off[15:1]);
    assign w_elig   = r_first || (r_erd.id > r_last);
    assign w_out_take = r_ovalid && !i_out_stall;

    always_comb begin
        priority if ({1'b0, r_erd.len} > w_rsum) begin
            w_rlen = r_maxl;
        end else if (r_erd.len > r_off) begin
            w_rlen = r_erd.len - r_off;
        end else begin
            w_rlen = 16'd0;
        end
    end

    always_comb begin
        o_stat.mode       = t_mode'(r_mode);
        o_stat.hdr_bad    = r_len[0] || (r_id == INVALID_ID);
        o_stat.rd_bad     = r_off[0] || r_maxl[0] || (r_id == INVALID_ID);
        o_stat.pend_nz    = (r_pend != '0);
        o_stat.over       = (17'(w_cnt_a) + 17'd1 > 17'(ENTRY_SLOTS - 2)) ||
                            (17'(w_fill_a) + 17'(w_hw) > 17'(DATA_HALFWORDS - 1));
        o_stat.k_zero     = (r_k == '0);
        o_stat.id_match   = (r_erd.id == r_id);
        o_stat.len_zero   = (r_erd.len == 16'd0);
        o_stat.rd_ok      = (w_rlen != 16'd0) && (w_ra < 17'(DATA_HALFWORDS));
        o_stat.scan_end   = (r_k == w_cnt_a);
        o_stat.none_found = r_bestid[16];
        o_stat.cnt_full   = (r_cnt[w_dst] >= CNT_W'(ENTRY_SLOTS));
        o_stat.step_done  = (r_i == r_hw);
        o_stat.out_free   = !r_ovalid || !i_out_stall;
    end

    // memory port steering
    always_comb begin
        e_we = 1'b0; e_wb = r_active; e_ws = '0; e_wd = '0;
        e_re = 1'b0; e_rb = r_active; e_rs = '0;
        d_we = 1'b0; d_wb = r_active; d_wa = '0; d_wd = '0;
        d_re = 1'b0; d_rb = r_active; d_ra = '0;
        unique case (i_cmd.op)
            OP_R_ADDR: begin
                e_re = 1'b1;
                e_rs = w_km1[SLOT_W-1:0];
            end
            OP_C_ADDR: begin
                e_re = 1'b1;
                e_rs = r_k[SLOT_W-1:0];
            end
            OP_C_PICK: begin
                e_re = 1'b1;
                e_rs = r_best;
            end
            OP_C_WENT: begin
                e_we = 1'b1;
                e_wb = w_dst;
                e_ws = r_cnt[w_dst][SLOT_W-1:0];
                e_wd = '{id: r_bestid[15:0], len: r_clen, addr: r_to};
            end
            OP_H_APP: begin
                e_we = 1'b1;
                e_ws = w_cnt_a[SLOT_W-1:0];
                e_wd = '{id: r_id, len: r_len, addr: w_fill_a};
            end
            OP_DATA_WR: begin
                d_we = 1'b1;
                d_wa = ADDR_W'(16'(w_fill_a) - 16'(r_pend));
                d_wd = r_din;
            end
            OP_C_CPWR: begin
                d_we = 1'b1;
                d_wb = w_dst;
                d_wa = ADDR_W'(16'(r_to) + 16'(r_i));
                d_wd = r_drd;
            end
            OP_H_CLR: begin
                d_we = 1'b1;
                d_wa = ADDR_W'(16'(w_fill_a) + 16'(r_i));
            end
            OP_D_ADDR: begin
                d_re = 1'b1;
                d_ra = w_ra[ADDR_W-1:0];
            end
            OP_C_CPRD: begin
                d_re = 1'b1;
                d_ra = ADDR_W'(16'(r_from) + 16'(r_i));
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (e_we) begin
            mem_e[e_wb][e_ws] <= e_wd;
        end
        if (e_re) begin
            r_erd <= mem_e[e_rb][e_rs];
        end
    end

    always_ff @(posedge i_clk) begin
        if (d_we) begin
            mem_d[d_wb][d_wa] <= d_wd;
        end
        if (d_re) begin
            r_drd <= mem_d[d_rb][d_ra];
        end
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_cnt[0] <= '0;
            r_cnt[1] <= '0;
            r_fill[0] <= '0;
            r_fill[1] <= '0;
            r_pend   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // a new result only loads once the old one is gone or leaving
            if (i_cmd.op == OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (w_out_take) begin
                r_ovalid <= 1'b0;
            end
            unique case (i_cmd.op)
                OP_DATA_WR: r_pend <= r_pend - HW_W'(1);
                OP_C_INIT: begin
                    r_cnt[w_dst]  <= '0;
                    r_fill[w_dst] <= '0;
                end
                OP_C_WENT: begin
                    r_cnt[w_dst]  <= r_cnt[w_dst] + CNT_W'(1);
                    r_fill[w_dst] <= FILL_W'(16'(r_to) + 16'(r_hw));
                end
                OP_C_END: r_active <= w_dst;
                OP_H_FIN: begin
                    r_cnt[r_active]  <= w_cnt_a + CNT_W'(1);
                    r_fill[r_active] <= FILL_W'(16'(w_fill_a) + 16'(r_hw));
                    r_pend           <= r_hw;
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LATCH: begin
                r_mode <= i_mode;
                r_id   <= i_object_id;
                r_len  <= i_length_bytes;
                r_off  <= i_read_offset;
                r_maxl <= i_max_length;
                r_din  <= i_data_in;
            end
            OP_RES, OP_DATA_WR, OP_H_FIN: begin
                r_rstat  <= (i_cmd.op == OP_RES) ? i_cmd.code : RS_OK;
                r_rfound <= 1'b0;
                r_rlen   <= 16'd0;
                r_rdout  <= 16'd0;
            end
            OP_R_INIT: r_k <= w_cnt_a;
            OP_R_ADDR: r_k <= w_km1;
            OP_R_HIT: begin
                r_rstat  <= RS_OK;
                r_rfound <= 1'b1;
                r_rlen   <= w_rlen;
                r_rdout  <= 16'd0;
            end
            OP_D_CAP: r_rdout <= r_drd;
            OP_C_INIT: r_first <= 1'b1;
            OP_C_SCAN0: begin
                r_k      <= '0;
                r_best   <= '0;
                r_bestid <= NO_ID;
            end
            OP_C_ADDR: begin
                r_kidx <= r_k[SLOT_W-1:0];
                r_k    <= r_k + CNT_W'(1);
            end
            OP_C_CHK: begin
                // lowest eligible id wins; a later entry of the same id is newer
                if (w_elig && ({1'b0, r_erd.id} < r_bestid)) begin
                    r_best   <= r_kidx;
                    r_bestid <= {1'b0, r_erd.id};
                end else if (w_elig && ({1'b0, r_erd.id} == r_bestid)) begin
                    r_best <= r_kidx;
                end
            end
            OP_C_ENT: begin
                r_hw   <= r_erd.len[15:1];
                r_from <= r_erd.addr;
                r_to   <= r_fill[w_dst];
                r_i    <= '0;
                r_clen <= r_erd.len;
            end
            OP_C_CPWR, OP_H_CLR: r_i <= r_i + HW_W'(1);
            OP_C_WENT: begin
                r_last  <= r_bestid[15:0];
                r_first <= 1'b0;
            end
            OP_H_APP: begin
                r_hw <= w_hw;
                r_i  <= '0;
            end
            OP_EMIT: begin
                o_status      <= r_rstat;
                o_found       <= r_rfound;
                o_read_length <= r_rlen;
                o_data_out    <= r_rdout;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_ovalid;

endmodule

// ----- hw/rtl/log_structured_object_store.sv -----
// ----------------------------------------------------------------------------
// log_structured_object_store: append-only id/length object store
// Two ping-pong banks of entry and data stacks with compaction on overflow.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one request: a header
//   (id, length; length 0 deletes), one data halfword, or a read. Output
//   channel (o_out_valid / i_out_stall) returns exactly one result per request.
//   A request is taken only while the sequencer is idle; o_in_stall is high
//   while a request is in progress. One finished result may wait in the
//   output register while the next request is already taken.
// Steps, with the sequencer doing one memory access at a time:
//   data halfword / rejected request: decode, then the result
//   header without compaction: append the entry (pending halfwords are zeroed)
//   read: entries scanned newest-first until the id is found or none is left,
//   then the data word when there is one
//   compaction: per surviving id one scan of the n entries of the old bank
//   and a copy of its halfwords, then a final scan, a setup and a check.
// Reset (synchronous, active low) empties both banks and selects bank zero;
// memory contents are not cleared, no sweep is needed. If the receiver
// stalls, the result holds in the output register and the finished request
// after it waits in its last step.
// ----------------------------------------------------------------------------
module log_structured_object_store import lsos_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_object_id,
    input  logic [15:0] i_length_bytes,
    input  logic [15:0] i_read_offset,
    input  logic [15:0] i_max_length,
    input  logic [15:0] i_data_in,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic        o_found,
    output logic [15:0] o_read_length,
    output logic [15:0] o_data_out
);

    t_cmd     w_cmd;
    t_dp_stat w_stat;
    logic     w_busy;

    // sequencer: one command to the datapath per cycle
    lsos_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy)
    );

    // memories, bank bookkeeping and result register
    lsos_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_mode         (i_mode),
        .i_object_id    (i_object_id),
        .i_length_bytes (i_length_bytes),
        .i_read_offset  (i_read_offset),
        .i_max_length   (i_max_length),
        .i_data_in      (i_data_in),
        .i_out_stall    (i_out_stall),
        .o_stat         (w_stat),
        .o_out_valid    (o_out_valid),
        .o_status       (o_status),
        .o_found        (o_found),
        .o_read_length  (o_read_length),
        .o_data_out     (o_data_out)
    );

    assign o_in_stall = w_busy;

endmodule

// ----- hw/rtl/lsos_chk.sv -----
// ----------------------------------------------------------------------------
// lsos_chk: port-level checks of the object store
// Input and output hold under stall and consistency of result fields.
// ----------------------------------------------------------------------------
module lsos_chk import lsos_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic [1:0]  i_mode,
    input logic [15:0] i_object_id,
    input logic [15:0] i_length_bytes,
    input logic [15:0] i_read_offset,
    input logic [15:0] i_max_length,
    input logic [15:0] i_data_in,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic        o_found,
    input logic [15:0] o_read_length,
    input logic [15:0] o_data_out
);

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_mode) &&
        $stable(i_object_id) && $stable(i_length_bytes) && $stable(i_read_offset) &&
        $stable(i_max_length) && $stable(i_data_in))
        else $error("request changed while stalled");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
        $stable(o_read_length) && $stable(o_data_out))
        else $error("result changed while stalled");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != RS_OK) |-> !o_found && (o_read_length == 16'd0))
        else $error("error result carries read fields");

    a_len_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_found |-> (o_read_length == 16'd0) && (o_data_out == 16'd0))
        else $error("read length without object");

    a_data_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_read_length == 16'd0) |-> (o_data_out == 16'd0))
        else $error("data without read length");

endmodule

bind log_structured_object_store lsos_chk u_lsos_chk (.*);

// ----- verif/tb.sv -----
// ----------------------------------------------------------------------------
// tb: testbench of log_structured_object_store
// A stimulus table and then random request sequences (headers with their data,
// reads, deletes, oversized objects, noise) go through the valid/stall
// channels. A behavioral copy of the store predicts each result not typed into
// the table, and each returned result is compared field by field, in order.
// ----------------------------------------------------------------------------
module tb;
    import lsos_pkg::*;

    typedef struct packed {
        logic [1:0]  status;
        logic        found;
        logic [15:0] rlen;
        logic [15:0] dout;
    } t_result;

    // Stimulus table row; chk set means the typed-in result is used.
    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] id;
        logic [15:0] len;
        logic [15:0] off;
        logic [15:0] maxl;
        logic [15:0] din;
        logic        chk;
        t_result     res;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_mode;
    logic [15:0] i_object_id;
    logic [15:0] i_length_bytes;
    logic [15:0] i_read_offset;
    logic [15:0] i_max_length;
    logic [15:0] i_data_in;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_status;
    logic        o_found;
    logic [15:0] o_read_length;
    logic [15:0] o_data_out;

    log_structured_object_store i_dut (.*);

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------- store copy
    logic [15:0] slot_id   [2][ENTRY_SLOTS];
    logic [15:0] slot_len  [2][ENTRY_SLOTS];
    int          slot_addr [2][ENTRY_SLOTS];
    logic [15:0] halfwords [2][DATA_HALFWORDS];
    int          cur_bank;
    int          slot_cnt [2];
    int          fill_cnt [2];
    int          pending_hw;

    t_result     result_queue[$];
    int          errors;
    int          req_count;
    bit          idle_on;
    bit          drained;

    function automatic bit needs_compaction(int b, int hw);
        return (slot_cnt[b] + 1 > ENTRY_SLOTS - 2) || (fill_cnt[b] + hw > DATA_HALFWORDS - 1);
    endfunction

    // Newest entry of each id moves to the other bank in ascending id order.
    function automatic void compact_banks();
        int src, dst, n, best, best_id, last_id, hw;
        bit keep [ENTRY_SLOTS];
        bit first;
        src = cur_bank;
        dst = src ^ 1;
        n = slot_cnt[src];
        first = 1'b1;
        last_id = 0;
        for (int k = 0; k < n; k++) begin
            keep[k] = 1'b1;
            for (int j = k + 1; j < n; j++)
                if (slot_id[src][j] == slot_id[src][k]) keep[k] = 1'b0;
        end
        slot_cnt[dst] = 0;
        fill_cnt[dst] = 0;
        forever begin
            best = n;
            best_id = 32'h10000;
            for (int k = 0; k < n; k++)
                if (keep[k] && (first || slot_id[src][k] > last_id) &&
                    slot_id[src][k] < best_id) begin
                    best = k;
                    best_id = slot_id[src][k];
                end
            if (best >= n || slot_cnt[dst] >= ENTRY_SLOTS) break;
            hw = slot_len[src][best] >> 1;
            for (int i = 0; i < hw; i++)
                if (slot_addr[src][best] + i < DATA_HALFWORDS &&
                    fill_cnt[dst] + i < DATA_HALFWORDS)
                    halfwords[dst][fill_cnt[dst] + i] = halfwords[src][slot_addr[src][best] + i];
            slot_id[dst][slot_cnt[dst]]   = best_id[15:0];
            slot_len[dst][slot_cnt[dst]]  = slot_len[src][best];
            slot_addr[dst][slot_cnt[dst]] = fill_cnt[dst];
            slot_cnt[dst]++;
            fill_cnt[dst] += hw;
            last_id = best_id;
            first = 1'b0;
        end
        cur_bank = dst;
    endfunction

    function automatic t_status append_header(logic [15:0] id, logic [15:0] len);
        int hw, b;
        if (len[0] || id == INVALID_ID) return RS_BAD;
        if (pending_hw != 0) return RS_SEQ;
        hw = len >> 1;
        if (needs_compaction(cur_bank, hw)) begin
            compact_banks();
            if (needs_compaction(cur_bank, hw)) return RS_FULL;
        end
        b = cur_bank;
        if (slot_cnt[b] >= ENTRY_SLOTS) return RS_FULL;
        slot_id[b][slot_cnt[b]]   = id;
        slot_len[b][slot_cnt[b]]  = len;
        slot_addr[b][slot_cnt[b]] = fill_cnt[b];
        for (int i = 0; i < hw; i++)
            if (fill_cnt[b] + i < DATA_HALFWORDS) halfwords[b][fill_cnt[b] + i] = '0;
        fill_cnt[b] += hw;
        slot_cnt[b]++;
        pending_hw = hw;
        return RS_OK;
    endfunction

    function automatic t_result store_request(logic [1:0] mode, logic [15:0] id,
            logic [15:0] len, logic [15:0] off, logic [15:0] maxl, logic [15:0] din);
        t_result r;
        int b, a, elen;
        r = '0;
        case (t_mode'(mode))
            MODE_HDR: r.status = append_header(id, len);
            MODE_DATA: begin
                if (pending_hw == 0) begin
                    r.status = RS_SEQ;
                end else begin
                    a = fill_cnt[cur_bank] - pending_hw;
                    if (a < DATA_HALFWORDS) halfwords[cur_bank][a] = din;
                    pending_hw--;
                end
            end
            MODE_READ: begin
                if (off[0] || maxl[0] || id == INVALID_ID) begin
                    r.status = RS_BAD;
                end else begin
                    b = cur_bank;
                    // newest entry of the id decides
                    for (int k = slot_cnt[b] - 1; k >= 0; k--) begin
                        if (slot_id[b][k] == id) begin
                            elen = slot_len[b][k];
                            if (elen != 0) begin
                                r.found = 1'b1;
                                if (elen > int'(maxl) + int'(off)) r.rlen = maxl;
                                else if (elen > off)               r.rlen = elen - off;
                                if (r.rlen != 0) begin
                                    a = slot_addr[b][k] + (off >> 1);
                                    if (a < DATA_HALFWORDS) r.dout = halfwords[b][a];
                                end
                            end
                            break;
                        end
                    end
                end
            end
            default: r.status = RS_BAD;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- sender
    // Drives one request and holds it until taken; valid stays high afterwards
    // so back-to-back requests need no second assignment in the same step.
    task automatic send_request(logic [1:0] mode, logic [15:0] id, logic [15:0] len,
            logic [15:0] off, logic [15:0] maxl, logic [15:0] din,
            bit typed = 1'b0, t_result typed_res = '0);
        t_result r;
        if (idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_mode         <= mode;
        i_object_id    <= id;
        i_length_bytes <= len;
        i_read_offset  <= off;
        i_max_length   <= maxl;
        i_data_in      <= din;
        do @(posedge i_clk); while (o_in_stall);
        r = store_request(mode, id, len, off, maxl, din);
        result_queue.push_back(typed ? typed_res : r);
        req_count++;
    endtask

    function automatic logic [15:0] pick_id();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90) return 16'($urandom_range(0, 11));
        if (r < 95) return 16'hFFFE;
        return 16'($urandom_range(0, 16'hFFFE));
    endfunction

    function automatic logic [15:0] pick_even(int hi);
        return 16'($urandom_range(0, hi) * 2);
    endfunction

    task automatic random_read();
        logic [15:0] off, maxl;
        off  = ($urandom_range(0, 9) == 0) ? pick_even(32767) : pick_even(24);
        maxl = ($urandom_range(0, 9) == 0) ? pick_even(32767) : pick_even(24);
        send_request(MODE_READ, pick_id(), 16'h0, off, maxl, 16'($urandom));
    endtask

    // Header then its data halfwords, reads mixed in.
    task automatic object_write();
        logic [15:0] len;
        int r;
        while (pending_hw != 0) send_request(MODE_DATA, '0, '0, '0, '0, 16'($urandom));
        r = $urandom_range(0, 99);
        if (r < 10)      len = 16'h0;
        else if (r < 85) len = pick_even(20);
        else if (r < 97) len = pick_even(300);
        else             len = pick_even(32767);
        send_request(MODE_HDR, pick_id(), len, '0, '0, '0);
        while (pending_hw != 0) begin
            if ($urandom_range(0, 6) == 0) random_read();
            send_request(MODE_DATA, '0, '0, '0, '0, 16'($urandom));
        end
    endtask

    localparam t_result RES_OK   = '{RS_OK, 1'b0, 16'h0, 16'h0};
    localparam t_result RES_BAD  = '{RS_BAD, 1'b0, 16'h0, 16'h0};
    localparam t_result RES_FULL = '{RS_FULL, 1'b0, 16'h0, 16'h0};
    localparam t_result RES_SEQ  = '{RS_SEQ, 1'b0, 16'h0, 16'h0};
    localparam t_result RES_NONE = '{RS_OK, 1'b0, 16'h0, 16'h0};

    t_row plan [] = '{
        '{MODE_READ, 16'd5,     16'd0,     16'd0,     16'd4,     16'd0,     1'b1, RES_NONE},
        '{MODE_RSVD, 16'd1,     16'd2,     16'd0,     16'd0,     16'd0,     1'b1, RES_BAD},
        '{MODE_DATA, 16'd0,     16'd0,     16'd0,     16'd0,     16'h1234,  1'b1, RES_SEQ},
        '{MODE_HDR,  16'd3,     16'd5,     16'd0,     16'd0,     16'd0,     1'b1, RES_BAD},
        '{MODE_HDR,  16'hFFFF,  16'd4,     16'd0,     16'd0,     16'd0,     1'b1, RES_BAD},
        '{MODE_READ, 16'd0,     16'd0,     16'd1,     16'd4,     16'd0,     1'b1, RES_BAD},
        '{MODE_READ, 16'd0,     16'd0,     16'd0,     16'hFFFF,  16'd0,     1'b1, RES_BAD},
        '{MODE_READ, 16'hFFFF,  16'd0,     16'd0,     16'd4,     16'd0,     1'b1, RES_BAD},
        '{MODE_HDR,  16'd0,     16'd4,     16'd0,     16'd0,     16'd0,     1'b1, RES_OK},
        // read while data is pending: unsent halfwords read as zero
        '{MODE_READ, 16'd0,     16'd0,     16'd0,     16'd4,     16'd0,     1'b0, RES_OK},
        '{MODE_HDR,  16'd1,     16'd2,     16'd0,     16'd0,     16'd0,     1'b1, RES_SEQ},
        '{MODE_DATA, 16'd0,     16'd0,     16'd0,     16'd0,     16'hFFFF,  1'b1, RES_OK},
        '{MODE_DATA, 16'hFFFF,  16'hFFFF,  16'hFFFF,  16'hFFFF,  16'h0000,  1'b1, RES_OK},
        '{MODE_READ, 16'd0,     16'd0,     16'd2,     16'hFFFE,  16'd0,     1'b0, RES_OK},
        '{MODE_HDR,  16'hFFFE,  16'd2,     16'd0,     16'd0,     16'd0,     1'b1, RES_OK},
        '{MODE_DATA, 16'd0,     16'd0,     16'd0,     16'd0,     16'hA5A5,  1'b1, RES_OK},
        '{MODE_READ, 16'hFFFE,  16'd0,     16'd0,     16'd0,     16'd0,     1'b0, RES_OK},
        '{MODE_READ, 16'hFFFE,  16'd0,     16'hFFFE,  16'hFFFE,  16'd0,     1'b0, RES_OK},
        // delete marker hides the object
        '{MODE_HDR,  16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     1'b1, RES_OK},
        '{MODE_READ, 16'd0,     16'd0,     16'd0,     16'd4,     16'd0,     1'b1, RES_NONE},
        // larger than the whole bank: compacts, then reports full
        '{MODE_HDR,  16'd1,     16'hFFFE,  16'd0,     16'd0,     16'd0,     1'b1, RES_FULL},
        '{MODE_READ, 16'hFFFE,  16'd0,     16'd0,     16'd2,     16'd0,     1'b0, RES_OK},
        '{MODE_READ, 16'd0,     16'd0,     16'd0,     16'd2,     16'd0,     1'b0, RES_OK}
    };

    // ---------------------------------------------------------------- receiver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (!idle_on) begin
            i_out_stall <= 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            i_out_stall <= 1'b1;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
            i_out_stall <= 1'b0;
            repeat ($urandom_range(0, 20)) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_queue.size() == 0) begin
                $display("%0t: result with none expected: status %0d", $realtime, o_status);
                errors++;
            end else begin
                want = result_queue.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $realtime, want.status, o_status);
                    errors++;
                end
                if (o_found !== want.found) begin
                    $display("%0t: found exp %0d got %0d", $realtime, want.found, o_found);
                    errors++;
                end
                if (o_read_length !== want.rlen) begin
                    $display("%0t: read_length exp %0h got %0h", $realtime, want.rlen,
                             o_read_length);
                    errors++;
                end
                if (o_data_out !== want.dout) begin
                    $display("%0t: data_out exp %0h got %0h", $realtime, want.dout, o_data_out);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------- main
    initial begin
        int sel;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_mode = '0;
        i_object_id = '0;
        i_length_bytes = '0;
        i_read_offset = '0;
        i_max_length = '0;
        i_data_in = '0;
        i_out_stall = 1'b0;
        errors = 0;
        req_count = 0;
        idle_on = 1'b1;
        drained = 1'b0;
        cur_bank = 0;
        slot_cnt = '{0, 0};
        fill_cnt = '{0, 0};
        pending_hw = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[n])
            send_request(plan[n].mode, plan[n].id, plan[n].len, plan[n].off,
                         plan[n].maxl, plan[n].din, plan[n].chk, plan[n].res);

        while (req_count < 1300) begin
            if (req_count > 1150) idle_on = 1'b0;
            // one drain: hold requests until every result is back
            if (!drained && req_count > 600) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                wait (result_queue.size() == 0);
                @(posedge i_clk);
            end
            sel = $urandom_range(0, 99);
            if (sel < 65) begin
                object_write();
            end else if (sel < 88) begin
                random_read();
            end else begin
                // noise: any field value, reserved mode included
                send_request(2'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom));
            end
        end
        i_in_valid <= 1'b0;

        wait (result_queue.size() == 0);
        repeat (50) @(posedge i_clk);
        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #40000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/lsos_pkg.sv
hw/rtl/lsos_ctrl.sv
hw/rtl/lsos_dpath.sv
hw/rtl/log_structured_object_store.sv
hw/rtl/lsos_chk.sv
verif/tb.sv
